@@ sv/bfa_pkg.sv @@
// Shared constants, codes and entry types for the best-fit arena allocator.
package bfa_pkg;

    localparam int GRANULES      = 1024;
    localparam int MAX_FREE      = 32;
    localparam int GRANULE_BYTES = 64;

    localparam int GW    = $clog2(GRANULES);       // granule index bits
    localparam int LW    = GW + 1;                  // granule count bits
    localparam int FW    = $clog2(MAX_FREE);        // free table index bits
    localparam int CW    = FW + 1;                  // free table count bits
    localparam int SHIFT = $clog2(GRANULE_BYTES);   // byte to granule shift
    localparam int CAPW  = 11;                      // capacity register width

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADFREE = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // free table entry: start granule and payload length
    typedef struct packed {
        logic [GW-1:0] start;
        logic [LW-1:0] len;
    } t_fent;

    // per-granule block start mark with the block length
    typedef struct packed {
        logic          valid;
        logic [LW-1:0] len;
    } t_mark;

endpackage

@@ sv/best_fit_arena_allocator_core.sv @@
// Best-fit arena allocator core: free table and block marks in synchronous RAMs.
// Allocate: a best-fit scan with one free table read per entry, plus entries moved when a
//   fully used entry is removed.
// Free: an ordered scan up to the block, plus entries moved on insert or on a two-sided merge.
// Clear and reset: a clearing pass over the block mark RAM; no items are taken during it.
// One item in flight; a finished result waits in the output register while the next is taken.
module best_fit_arena_allocator_core
    import bfa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [55:0]     s_axis_tdata,  // operation, size_bytes, payload_offset
    input  logic [0:0]      s_axis_tuser,  // is_null
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [39:0]     m_axis_tdata,  // status, result_offset, error_sticky, peak_bytes
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CAPW-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_A_SCAN, S_A_FIT, S_A_MARK, S_F_RD, S_F_CHK, S_F_SCAN,
        S_F_DEC, S_SHD_RD, S_SHD_WR, S_SHU_RD, S_SHU_WR, S_DONE
    } t_state;

    t_state          r_state;
    logic [CAPW-1:0] r_cap;
    logic [CW-1:0]   r_count;
    logic [LW-1:0]   r_cursor;
    logic [LW-1:0]   r_peak;
    logic            r_err;
    logic [CW-1:0]   r_idx;
    logic            r_rv;
    logic [FW-1:0]   r_vidx;
    logic            r_bvalid;
    logic [FW-1:0]   r_bidx;
    logic [LW-1:0]   r_blen;
    logic [GW-1:0]   r_bstart;
    logic [LW-1:0]   r_want;
    logic            r_huge;
    logic [GW-1:0]   r_blk;
    logic [LW-1:0]   r_len;
    t_fent           r_prev;
    t_fent           r_next;
    logic            r_hasnext;
    logic [CW-1:0]   r_p;
    logic [CW-1:0]   r_j;
    logic            r_isfree;
    t_status         r_status;
    logic [15:0]     r_off;
    logic [GW-1:0]   r_sw;
    logic            r_sweep;
    logic            r_ovalid;
    logic [39:0]     r_odata;

    // memories
    t_fent         ftab [MAX_FREE];
    t_fent         ft_rd;
    logic          ft_we;
    logic [FW-1:0] ft_wa;
    t_fent         ft_wd;
    logic [FW-1:0] ft_ra;
    t_mark         mtab [GRANULES];
    t_mark         mk_rd;
    logic          mk_we;
    logic [GW-1:0] mk_wa;
    t_mark         mk_wd;

    // input fields
    logic [1:0]         in_op;
    logic [31:0]        in_size;
    logic [15:0]        in_off;
    logic               in_null;
    logic [32-SHIFT:0]  wsum;
    logic [CAPW-1:0]    cap_eff;
    logic               in_acc;

    logic [LW-1:0] rem;
    logic [LW:0]   cap_left;
    logic          mnext;
    logic          mprev;
    logic [LW:0]   next_end;
    logic [LW:0]   prev_end;

    assign in_op   = s_axis_tdata[1:0];
    assign in_size = s_axis_tdata[33:2];
    assign in_off  = s_axis_tdata[49:34];
    assign in_null = s_axis_tuser[0];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // derived values
    assign cap_eff  = (r_cap > CAPW'(GRANULES)) ? CAPW'(GRANULES) : r_cap;
    assign wsum     = (32-SHIFT+1)'(in_size[31:SHIFT]) + (32-SHIFT+1)'(|in_size[SHIFT-1:0]);
    assign rem      = r_blen - r_want;
    assign cap_left = (LW+1)'(cap_eff) - (LW+1)'(r_cursor);
    assign next_end = (LW+1)'(r_blk) + (LW+1)'(1) + (LW+1)'(r_len);
    assign prev_end = (LW+1)'(r_prev.start) + (LW+1)'(1) + (LW+1)'(r_prev.len);
    assign mnext    = r_hasnext && (next_end == (LW+1)'(r_next.start));
    assign mprev    = (r_p != '0) && (prev_end == (LW+1)'(r_blk));

    // free table RAM
    always_ff @(posedge i_clk) begin
        if (ft_we) begin
            ftab[ft_wa] <= ft_wd;
        end
        ft_rd <= ftab[ft_ra];
    end

    // block mark RAM
    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            mtab[mk_wa] <= mk_wd;
        end
        mk_rd <= mtab[r_blk];
    end

    // RAM port control
    always_comb begin
        ft_we = 1'b0;
        ft_wa = r_j[FW-1:0];
        ft_wd = ft_rd;
        ft_ra = r_idx[FW-1:0];
        mk_we = 1'b0;
        mk_wa = r_blk;
        mk_wd = '0;
        case (r_state)
            S_SWEEP: begin
                mk_we = 1'b1;
                mk_wa = r_sw;
            end
            S_A_FIT: begin
                ft_wa = r_bidx;
                ft_wd.start = r_bstart + GW'(r_want) + GW'(1);
                ft_wd.len   = rem - LW'(1);
                ft_we = r_bvalid && (rem >= LW'(2));
            end
            S_A_MARK: begin
                mk_we = 1'b1;
                mk_wd.valid = 1'b1;
                mk_wd.len   = r_want;
            end
            S_F_DEC: begin
                mk_we = mprev || mnext || (r_count < CW'(MAX_FREE));
                if (mprev && mnext) begin
                    ft_we = 1'b1;
                    ft_wa = FW'(r_p - CW'(1));
                    ft_wd.start = r_prev.start;
                    ft_wd.len   = r_prev.len + r_len + r_next.len + LW'(2);
                end else if (mprev) begin
                    ft_we = 1'b1;
                    ft_wa = FW'(r_p - CW'(1));
                    ft_wd.start = r_prev.start;
                    ft_wd.len   = r_prev.len + r_len + LW'(1);
                end else if (mnext) begin
                    ft_we = 1'b1;
                    ft_wa = r_p[FW-1:0];
                    ft_wd.start = r_blk;
                    ft_wd.len   = r_len + r_next.len + LW'(1);
                end
            end
            S_SHD_RD: begin
                ft_ra = FW'(r_j + CW'(1));
            end
            S_SHD_WR: begin
                ft_we = 1'b1;
            end
            S_SHU_RD: begin
                ft_ra = FW'(r_j - CW'(1));
                if (r_j <= r_p) begin
                    ft_we = 1'b1;
                    ft_wa = r_p[FW-1:0];
                    ft_wd.start = r_blk;
                    ft_wd.len   = r_len;
                end
            end
            S_SHU_WR: begin
                ft_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_count  <= '0;
            r_cursor <= '0;
            r_peak   <= '0;
            r_err    <= 1'b0;
            r_sw     <= '0;
            r_sweep  <= 1'b0;
            r_ovalid <= 1'b0;
            r_rv     <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    r_sw <= r_sw + GW'(1);
                    if (r_sw == GW'(GRANULES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_off     <= '0;
                        r_sweep   <= (in_op == OP_CLEAR);
                        r_idx     <= '0;
                        r_rv      <= 1'b0;
                        r_bvalid  <= 1'b0;
                        r_p       <= '0;
                        r_hasnext <= 1'b0;
                        r_want    <= (in_size == '0) ? LW'(1) : wsum[LW-1:0];
                        r_huge    <= |wsum[32-SHIFT:LW];
                        r_blk     <= GW'(in_off[15:SHIFT]) - GW'(1);
                        case (in_op)
                            OP_ALLOC: begin
                                if (cap_eff == '0) begin
                                    r_status <= ST_NOSPACE;
                                    r_err    <= 1'b1;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_A_SCAN;
                                end
                            end
                            OP_FREE: begin
                                if (in_null) begin
                                    r_status <= ST_OK;
                                    r_state  <= S_DONE;
                                end else if (cap_eff == '0) begin
                                    r_status <= ST_NOSPACE;
                                    r_err    <= 1'b1;
                                    r_state  <= S_DONE;
                                end else if ({1'b0, in_off} >= {cap_eff, SHIFT'(0)}
                                             || in_off[15:SHIFT] == '0
                                             || in_off[SHIFT-1:0] != '0) begin
                                    r_status <= ST_BADFREE;
                                    r_err    <= 1'b1;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_F_RD;
                                end
                            end
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_cursor <= '0;
                                r_peak   <= '0;
                                r_err    <= 1'b0;
                                r_sw     <= '0;
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                // best-fit scan, one entry per cycle
                S_A_SCAN: begin
                    if (r_rv && !r_huge && ft_rd.len >= r_want
                        && (!r_bvalid || ft_rd.len < r_blen)) begin
                        r_bvalid <= 1'b1;
                        r_bidx   <= r_vidx;
                        r_blen   <= ft_rd.len;
                        r_bstart <= ft_rd.start;
                    end
                    if (r_idx < r_count) begin
                        r_rv   <= 1'b1;
                        r_vidx <= r_idx[FW-1:0];
                        r_idx  <= r_idx + CW'(1);
                    end else begin
                        r_rv <= 1'b0;
                        if (!r_rv) begin
                            r_state <= S_A_FIT;
                        end
                    end
                end
                S_A_FIT: begin
                    if (r_bvalid) begin
                        r_blk <= r_bstart;
                        if (rem >= LW'(2)) begin
                            r_state <= S_A_MARK;
                        end else begin
                            r_j      <= CW'(r_bidx);
                            r_isfree <= 1'b0;
                            r_state  <= S_SHD_RD;
                        end
                    end else if (r_cursor >= LW'(cap_eff) || r_huge
                                 || (LW+1)'(r_want) + (LW+1)'(1) > cap_left) begin
                        r_status <= ST_NOSPACE;
                        r_err    <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_blk    <= r_cursor[GW-1:0];
                        r_cursor <= r_cursor + r_want + LW'(1);
                        if (r_cursor + r_want + LW'(1) > r_peak) begin
                            r_peak <= r_cursor + r_want + LW'(1);
                        end
                        r_state <= S_A_MARK;
                    end
                end
                S_A_MARK: begin
                    r_status <= ST_OK;
                    r_off    <= 16'(({5'b0, r_blk} + 16'd1) << SHIFT);
                    r_state  <= S_DONE;
                end
                S_F_RD: begin
                    r_state <= S_F_CHK;
                end
                S_F_CHK: begin
                    if (!mk_rd.valid) begin
                        r_status <= ST_BADFREE;
                        r_err    <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_len   <= mk_rd.len;
                        r_state <= S_F_SCAN;
                    end
                end
                // ordered scan for the insert point
                S_F_SCAN: begin
                    if (r_rv && ft_rd.start >= r_blk) begin
                        r_next    <= ft_rd;
                        r_hasnext <= 1'b1;
                        r_rv      <= 1'b0;
                        r_state   <= S_F_DEC;
                    end else begin
                        if (r_rv) begin
                            r_prev <= ft_rd;
                            r_p    <= CW'(r_vidx) + CW'(1);
                        end
                        if (r_idx < r_count) begin
                            r_rv   <= 1'b1;
                            r_vidx <= r_idx[FW-1:0];
                            r_idx  <= r_idx + CW'(1);
                        end else begin
                            r_rv <= 1'b0;
                            if (!r_rv) begin
                                r_state <= S_F_DEC;
                            end
                        end
                    end
                end
                S_F_DEC: begin
                    r_isfree <= 1'b1;
                    if (!mprev && !mnext && r_count >= CW'(MAX_FREE)) begin
                        r_status <= ST_FULL;
                        r_err    <= 1'b1;
                        r_state  <= S_DONE;
                    end else if (mprev && mnext) begin
                        r_status <= ST_OK;
                        r_j      <= r_p;
                        r_state  <= S_SHD_RD;
                    end else if (!mprev && !mnext) begin
                        r_status <= ST_OK;
                        r_j      <= r_count;
                        r_state  <= S_SHU_RD;
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                    end
                end
                // close the gap: entry j takes entry j+1
                S_SHD_RD: begin
                    if (r_j + CW'(1) < r_count) begin
                        r_state <= S_SHD_WR;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= r_isfree ? S_DONE : S_A_MARK;
                    end
                end
                S_SHD_WR: begin
                    r_j     <= r_j + CW'(1);
                    r_state <= S_SHD_RD;
                end
                // open a gap: entry j takes entry j-1
                S_SHU_RD: begin
                    if (r_j > r_p) begin
                        r_state <= S_SHU_WR;
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_SHU_WR: begin
                    r_j     <= r_j - CW'(1);
                    r_state <= S_SHU_RD;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'b0, r_peak, SHIFT'(0), r_err, r_off, r_status};
                        r_state  <= r_sweep ? S_SWEEP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FREE))
        else $error("free table count beyond its depth");

    a_peak_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_cursor)
        else $error("peak cursor below bump cursor");

    a_sweep_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_count == '0 && r_cursor == '0))
        else $error("clearing pass with a non-empty arena");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE && r_state != S_SWEEP))
        else $error("accepted item not taken into work");

endmodule
